[design/ipls_pkg.sv]
// Shared types and constants for the ignition power latch sequencer.
// No dependencies; imported by the sequencer unit, its checker and the testbench.
`timescale 1ns / 1ps

package ipls_pkg;

  typedef enum logic [1:0] {
    MODE_BOOT  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_COUNT = 2'd2,
    MODE_SHUT  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_RUN_THRESHOLD = 2'd0,
    REG_SHUTDOWN_DLY  = 2'd1,
    REG_BOOT_WAIT     = 2'd2,
    REG_DIVIDER_RATIO = 2'd3
  } reg_idx_e;

  localparam int unsigned AdcW      = 12;
  localparam int unsigned MvW       = 16;
  localparam int unsigned TicksW    = 20;
  localparam int unsigned RatioW    = 12;
  localparam int unsigned CfgW      = 20;
  localparam int unsigned FiltW     = 32;
  localparam int unsigned TimerW    = 7;

  localparam logic [TimerW-1:0] SamplePeriod = 7'd100;
  localparam logic [TicksW-1:0] ElapsedMax   = 20'hFFFFF;
  localparam logic [13:0]       FilterGain   = 14'd9830;   // 0.15 in Q0.16

  localparam logic [MvW-1:0]    RunThresholdRst = 16'd13200;
  localparam logic [TicksW-1:0] ShutdownDlyRst  = 20'd30000;
  localparam logic [MvW-1:0]    BootWaitRst     = 16'd5000;
  localparam logic [RatioW-1:0] DividerRatioRst = 12'd1280;
  localparam logic [FiltW-1:0]  FiltRst         = {16'd12600, 16'd0};

endpackage

[design/ignition_power_latch_sequencer_unit.sv]
// Ignition power latch sequencer: battery filter, engine detect and mode sequencing.
// Depends on ipls_pkg.
`timescale 1ns / 1ps

//  channel | signals                                  | beat
//  --------+------------------------------------------+---------------------------
//  in      | in_valid_i/in_ready_o, adc_mv_i, sense   | one millisecond tick
//  out     | out_valid_o/out_ready_i, five result pins| one result per tick
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i          | one register write
//
// One tick per clock cycle while the output is not stalled; a tick passes the scaling
// register, then the state update into the result register. The divider scaling
// multiply and the filter gain multiply sit in separate stages. Reset restores the
// register defaults and the seed state. A stalled output holds the pipeline; the
// input side keeps accepting while the scaling stage is empty.

module ignition_power_latch_sequencer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ipls_pkg::AdcW-1:0]   adc_mv_i,
  input  logic                        sense_high_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  mode_code_o,
  output logic                        engine_running_o,
  output logic [ipls_pkg::MvW-1:0]    battery_mv_o,
  output logic [ipls_pkg::TicksW-1:0] remaining_ms_o,
  output logic                        shutdown_request_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [ipls_pkg::CfgW-1:0]   cfg_data_i
);
  import ipls_pkg::*;

  // configuration
  logic [MvW-1:0]    thr_q;
  logic [TicksW-1:0] dly_q;
  logic [MvW-1:0]    boot_wait_q;
  logic [RatioW-1:0] ratio_q;

  // scaling stage
  logic              s1_valid_q;
  logic [MvW-1:0]    s1_sample_q;
  logic              s1_sense_q;

  // sequencer state
  mode_e             mode_q, mode_d;
  logic [FiltW-1:0]  filt_q, filt_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic [TicksW-1:0] elapsed_q, elapsed_d;
  logic              armed_q, armed_d;
  logic              seeded_q;

  // result register
  logic              out_valid_q;
  logic [1:0]        res_mode_q;
  logic              res_active_q;
  logic [MvW-1:0]    res_mv_q;
  logic [TicksW-1:0] res_remain_q;
  logic              res_shut_q;

  logic                    advance;
  logic                    take_in;
  logic [2*AdcW-1:0]       scaled_full;
  logic [TimerW-1:0]       timer_inc;
  logic                    filter_hit;
  logic signed [33:0]      diff;
  logic signed [47:0]      prod;
  logic signed [34:0]      filt_next;
  logic [TicksW-1:0]       elapsed_inc;
  logic                    active;
  logic [TicksW-1:0]       remain_d;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign take_in    = in_valid_i && in_ready_o;

  // adc * Q4.8 ratio stays below 2^24, so the top 16 bits never overflow
  assign scaled_full = adc_mv_i * ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= RunThresholdRst;
      dly_q       <= ShutdownDlyRst;
      boot_wait_q <= BootWaitRst;
      ratio_q     <= DividerRatioRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RUN_THRESHOLD: thr_q       <= cfg_data_i[MvW-1:0];
        REG_SHUTDOWN_DLY:  dly_q       <= cfg_data_i[TicksW-1:0];
        REG_BOOT_WAIT:     boot_wait_q <= cfg_data_i[MvW-1:0];
        REG_DIVIDER_RATIO: ratio_q     <= cfg_data_i[RatioW-1:0];
        default:           thr_q       <= thr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      s1_sample_q <= scaled_full[MvW+7:8];
      s1_sense_q  <= sense_high_i;
    end
  end

  // filter arithmetic; the step always lands between old value and sample
  assign timer_inc   = timer_q + TimerW'(1);
  assign filter_hit  = timer_inc >= SamplePeriod;
  assign diff        = $signed({2'b00, s1_sample_q, 16'd0}) - $signed({2'b00, filt_q});
  assign prod        = 48'(diff) * $signed({1'b0, FilterGain});
  assign filt_next   = $signed({3'b000, filt_q}) + 35'(prod >>> 16);
  assign elapsed_inc = (elapsed_q < ElapsedMax) ? elapsed_q + TicksW'(1) : elapsed_q;

  // next state
  always_comb begin
    mode_d    = mode_q;
    filt_d    = filt_q;
    timer_d   = timer_q;
    elapsed_d = elapsed_q;
    armed_d   = armed_q;
    active    = 1'b0;
    if (!seeded_q) begin
      filt_d  = {s1_sample_q, 16'd0};
      timer_d = '0;
      active  = s1_sense_q || (filt_d[FiltW-1:16] >= thr_q);
      mode_d  = active ? MODE_RUN : MODE_BOOT;
    end else begin
      if (filter_hit) begin
        timer_d = '0;
        filt_d  = filt_next[FiltW-1:0];
      end else begin
        timer_d = timer_inc;
      end
      elapsed_d = elapsed_inc;
      active    = s1_sense_q || (filt_d[FiltW-1:16] >= thr_q);
      case (mode_q)
        MODE_BOOT: begin
          if (active) begin
            mode_d = MODE_RUN;
          end else if (!armed_q) begin
            armed_d   = 1'b1;
            elapsed_d = '0;
          end else if (elapsed_inc >= {4'd0, boot_wait_q}) begin
            mode_d    = MODE_COUNT;
            elapsed_d = '0;
          end
        end
        MODE_RUN: begin
          if (!active) begin
            mode_d    = MODE_COUNT;
            armed_d   = 1'b1;
            elapsed_d = '0;
          end
        end
        MODE_COUNT: begin
          if (active) begin
            mode_d  = MODE_RUN;
            armed_d = 1'b0;
          end else if (elapsed_inc >= dly_q) begin
            mode_d = MODE_SHUT;
          end
        end
        default: mode_d = MODE_SHUT;
      endcase
    end
  end

  // result fields
  always_comb begin
    remain_d = '0;
    if (mode_d == MODE_COUNT && elapsed_d < dly_q) begin
      remain_d = dly_q - elapsed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_BOOT;
      filt_q      <= FiltRst;
      timer_q     <= '0;
      elapsed_q   <= '0;
      armed_q     <= 1'b0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        mode_q    <= mode_d;
        filt_q    <= filt_d;
        timer_q   <= timer_d;
        elapsed_q <= elapsed_d;
        armed_q   <= armed_d;
        seeded_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      res_mode_q   <= mode_d;
      res_active_q <= active;
      res_mv_q     <= filt_d[FiltW-1:16];
      res_remain_q <= remain_d;
      res_shut_q   <= (mode_d == MODE_SHUT);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign mode_code_o        = res_mode_q;
  assign engine_running_o   = res_active_q;
  assign battery_mv_o       = res_mv_q;
  assign remaining_ms_o     = res_remain_q;
  assign shutdown_request_o = res_shut_q;

endmodule

[design/ipls_checker.sv]
// Port-level checks for the ignition power latch sequencer, bound to the top level.
// Depends on ipls_pkg and ignition_power_latch_sequencer_unit.
`timescale 1ns / 1ps

module ipls_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [1:0]                  mode_code_o,
  input logic                        engine_running_o,
  input logic [ipls_pkg::MvW-1:0]    battery_mv_o,
  input logic [ipls_pkg::TicksW-1:0] remaining_ms_o,
  input logic                        shutdown_request_o
);
  import ipls_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mode_code_o)
      && $stable(battery_mv_o) && $stable(remaining_ms_o))
    else $error("result beat changed while stalled");

  a_shut_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (shutdown_request_o == (mode_code_o == MODE_SHUT)))
    else $error("shutdown request disagrees with mode");

  a_remain_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_code_o != MODE_COUNT |-> remaining_ms_o == '0)
    else $error("remaining time outside countdown");

  // running mode is only ever entered or kept with an active engine
  a_run_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_code_o == MODE_RUN |-> engine_running_o)
    else $error("running mode without active engine");

endmodule

bind ignition_power_latch_sequencer_unit ipls_checker u_ipls_checker (.*);

[dv/tb_ignition_power_latch_sequencer_unit.sv]
// Testbench for the ignition power latch sequencer: random and directed ticks, scoreboard check.
// Depends on ipls_pkg and ignition_power_latch_sequencer_unit.
`timescale 1ns / 1ps

module tb_ignition_power_latch_sequencer_unit;
  import ipls_pkg::*;

  localparam int unsigned TICKS_PER_SAMPLE = 100;
  localparam longint      FILT_GAIN        = 9830;
  localparam logic [19:0] ELAPSED_CAP      = 20'hFFFFF;
  localparam int          CYCLE_LIMIT      = 200000;
  localparam int          STALL_AT_RESULT  = 60;
  localparam int          STALL_CYCLES     = 300;

  typedef struct packed {
    logic [AdcW-1:0] adc;
    logic            sense;
  } tick_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic              running;
    logic [MvW-1:0]    batt;
    logic [TicksW-1:0] rem;
    logic              shut;
  } tick_result_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [AdcW-1:0]   adc_mv_i     = '0;
  logic              sense_high_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [1:0]        mode_code_o;
  logic              engine_running_o;
  logic [MvW-1:0]    battery_mv_o;
  logic [TicksW-1:0] remaining_ms_o;
  logic              shutdown_request_o;
  logic              cfg_we_i     = 1'b0;
  logic [1:0]        cfg_idx_i    = '0;
  logic [CfgW-1:0]   cfg_data_i   = '0;

  ignition_power_latch_sequencer_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .adc_mv_i           (adc_mv_i),
    .sense_high_i       (sense_high_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .mode_code_o        (mode_code_o),
    .engine_running_o   (engine_running_o),
    .battery_mv_o       (battery_mv_o),
    .remaining_ms_o     (remaining_ms_o),
    .shutdown_request_o (shutdown_request_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register mirror
  logic [MvW-1:0]    cfg_run_thr   = RunThresholdRst;
  logic [TicksW-1:0] cfg_shut_dly  = ShutdownDlyRst;
  logic [MvW-1:0]    cfg_boot_wait = BootWaitRst;
  logic [RatioW-1:0] cfg_div_ratio = DividerRatioRst;

  // sequencer state as predicted
  mode_e             lp_mode     = MODE_BOOT;
  logic [FiltW-1:0]  lp_filt_q16 = FiltRst;
  logic [TimerW-1:0] lp_tmr      = '0;
  logic [TicksW-1:0] lp_elapsed  = '0;
  logic              lp_armed    = 1'b0;
  logic              lp_seeded   = 1'b0;

  tick_t        ticks_to_send[$];
  tick_result_t tick_results_due[$];
  tick_t        drv_tick;
  tick_result_t got_result;
  tick_result_t want_result;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  results_seen  = 0;
  int  err_count     = 0;
  int  cycles        = 0;
  int  stall_left    = 0;
  bit  stall_done    = 1'b0;
  logic in_fire_q    = 1'b0;

  function automatic tick_result_t next_tick_result(logic [AdcW-1:0] adc, logic sense);
    int unsigned  sample;
    longint       diff;
    longint       step;
    longint       nxt;
    logic         active;
    tick_result_t r;
    sample = (32'(adc) * 32'(cfg_div_ratio)) >> 8;
    if (sample > 65535) sample = 65535;
    if (!lp_seeded) begin
      lp_seeded   = 1'b1;
      lp_filt_q16 = {sample[15:0], 16'h0};
      lp_tmr      = '0;
      active      = sense || (lp_filt_q16[31:16] >= cfg_run_thr);
      lp_mode     = active ? MODE_RUN : MODE_BOOT;
    end else begin
      lp_tmr = lp_tmr + 1'b1;
      if (lp_tmr >= TICKS_PER_SAMPLE) begin
        lp_tmr = '0;
        diff = (longint'(sample) <<< 16) - longint'(lp_filt_q16);
        step = (diff * FILT_GAIN) >>> 16;
        nxt  = longint'(lp_filt_q16) + step;
        if (nxt < 0) nxt = 0;
        if (nxt > 64'hFFFF_FFFF) nxt = 64'hFFFF_FFFF;
        lp_filt_q16 = nxt[31:0];
      end
      if (lp_elapsed < ELAPSED_CAP) lp_elapsed = lp_elapsed + 1'b1;
      active = sense || (lp_filt_q16[31:16] >= cfg_run_thr);
      case (lp_mode)
        MODE_BOOT: begin
          if (active) begin
            lp_mode = MODE_RUN;
          end else if (!lp_armed) begin
            lp_armed   = 1'b1;
            lp_elapsed = '0;
          end else if (lp_elapsed >= TicksW'(cfg_boot_wait)) begin
            lp_mode    = MODE_COUNT;
            lp_elapsed = '0;
          end
        end
        MODE_RUN: begin
          if (!active) begin
            lp_mode    = MODE_COUNT;
            lp_armed   = 1'b1;
            lp_elapsed = '0;
          end
        end
        MODE_COUNT: begin
          if (active) begin
            lp_mode  = MODE_RUN;
            lp_armed = 1'b0;
          end else if (lp_elapsed >= cfg_shut_dly) begin
            lp_mode = MODE_SHUT;
          end
        end
        default: lp_mode = MODE_SHUT;
      endcase
    end
    r.mode    = lp_mode;
    r.running = active;
    r.batt    = lp_filt_q16[31:16];
    r.rem     = (lp_mode == MODE_COUNT && lp_elapsed < cfg_shut_dly) ?
                cfg_shut_dly - lp_elapsed : '0;
    r.shut    = (lp_mode == MODE_SHUT);
    return r;
  endfunction

  // input driver: advance to the next beat once the current one is taken
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire_q) begin
      if (ticks_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_tick = ticks_to_send.pop_front();
        in_valid_i   <= 1'b1;
        adc_mv_i     <= drv_tick.adc;
        sense_high_i <= drv_tick.sense;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver; one long hold-off lets the block back up into its input
  always @(negedge clk_i) begin
    if (!stall_done && results_seen >= STALL_AT_RESULT) begin
      stall_done = 1'b1;
      stall_left = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left  = stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire_q <= 1'b0;
    end else begin
      in_fire_q <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        tick_results_due.push_back(next_tick_result(adc_mv_i, sense_high_i));
      end
      if (out_valid_o && out_ready_i) begin
        results_seen = results_seen + 1;
        got_result = {mode_code_o, engine_running_o, battery_mv_o, remaining_ms_o,
                      shutdown_request_o};
        if (tick_results_due.size() == 0) begin
          err_count = err_count + 1;
          if (err_count <= 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          want_result = tick_results_due.pop_front();
          if (got_result !== want_result) begin
            err_count = err_count + 1;
            if (err_count <= 10) begin
              $display("result %0d differs (exp/got): mode %0d/%0d run %0b/%0b batt %0d/%0d",
                       results_seen, want_result.mode, got_result.mode, want_result.running,
                       got_result.running, want_result.batt, got_result.batt);
              $display("  remaining %0d/%0d shutdown %0b/%0b", want_result.rem, got_result.rem,
                       want_result.shut, got_result.shut);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_RUN_THRESHOLD: cfg_run_thr   = val[MvW-1:0];
      REG_SHUTDOWN_DLY:  cfg_shut_dly  = val[TicksW-1:0];
      REG_BOOT_WAIT:     cfg_boot_wait = val[MvW-1:0];
      default:           cfg_div_ratio = val[RatioW-1:0];
    endcase
  endtask

  task automatic write_regs(logic [CfgW-1:0] thr, logic [CfgW-1:0] dly,
                            logic [CfgW-1:0] boot, logic [CfgW-1:0] div);
    write_reg(REG_RUN_THRESHOLD, thr);
    write_reg(REG_SHUTDOWN_DLY, dly);
    write_reg(REG_BOOT_WAIT, boot);
    write_reg(REG_DIVIDER_RATIO, div);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (ticks_to_send.size() != 0 || in_valid_i || tick_results_due.size() != 0);
  endtask

  task automatic push_tick(int adc, bit sense);
    tick_t t;
    if (adc < 0) adc = 0;
    if (adc > 4095) adc = 4095;
    t.adc   = adc[AdcW-1:0];
    t.sense = sense;
    ticks_to_send.push_back(t);
  endtask

  // bursts of steady sense with readings near the threshold, near a random level or fully random, plus noise
  task automatic queue_random_ticks(int n, int sense_pct);
    int left;
    int run_len;
    int target;
    int base;
    int pick;
    int a;
    bit run_sense;
    bit s;
    left = n;
    if (cfg_div_ratio == 0) target = 4095;
    else target = (int'(cfg_run_thr) * 256) / int'(cfg_div_ratio);
    if (target > 4095) target = 4095;
    while (left > 0) begin
      run_len = $urandom_range(30, 1);
      if (run_len > left) run_len = left;
      left      = left - run_len;
      run_sense = ($urandom_range(99) < sense_pct);
      pick      = $urandom_range(2);
      base      = (pick == 2) ? int'($urandom_range(4095)) : target;
      repeat (run_len) begin
        case (pick)
          0:       a = $urandom_range(4095);
          1:       a = target + int'($urandom_range(400)) - 200;
          default: a = base + int'($urandom_range(16)) - 8;
        endcase
        s = run_sense;
        if (sense_pct > 0 && $urandom_range(9) == 0) s = !s;
        push_tick(a, s);
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // upper data bits beyond the threshold width must be dropped
    write_regs(20'hF0000 | 20'd13200, 20'd40, 20'($urandom_range(4)), 20'd1280);
    send_idle_pct = 25;
    recv_idle_pct = 82;

    // quiet seed: boot, arm, wait out the boot time, then count down
    repeat (9) push_tick(0, 1'b0);
    push_tick(4095, 1'b1);
    push_tick(4095, 1'b0);
    push_tick(0, 1'b0);
    push_tick(0, 1'b1);
    push_tick(2048, 1'b0);
    push_tick(4095, 1'b1);
    push_tick(1, 1'b0);
    push_tick(4094, 1'b0);
    push_tick(0, 1'b1);
    push_tick(4095, 1'b0);
    wait_drained();

    write_regs(20'd13200, 20'hFFFFF, 20'd65535, 20'd4095);
    queue_random_ticks(130, 50);
    wait_drained();

    send_idle_pct = 82;
    recv_idle_pct = 25;
    write_regs(20'd0, 20'd30000, 20'd0, 20'd256);
    queue_random_ticks(110, 40);
    wait_drained();

    // divider below its nominal range is taken as written
    write_regs(20'd65535, 20'd500, 20'd1000, 20'd100);
    queue_random_ticks(110, 50);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_regs(20'($urandom_range(20000, 8000)), 20'($urandom_range(300, 50)),
               20'($urandom_range(65535)), 20'($urandom_range(4095, 256)));
    queue_random_ticks(130, 55);
    wait_drained();

    // zero grace period: drop sense at the tail and latch into shutdown
    write_regs(20'd65535, 20'd0, 20'd5000, 20'd1280);
    queue_random_ticks(40, 60);
    queue_random_ticks(30, 0);
    wait_drained();

    repeat (10) @(posedge clk_i);
    #1;
    if (err_count == 0 && tick_results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
